// File: src/iar_pkg.sv
// ----------------------------------------------------------------------------
// iar_pkg
// Shared types and constants of the int8 activation requantize unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iar_pkg;

    // fixed point formats of the scale registers
    localparam int IN_FRAC  = 24;
    localparam int OUT_FRAC = 16;

    // activation mode codes (the fourth code acts as linear)
    localparam logic [1:0] MODE_SIGMOID    = 2'd0;
    localparam logic [1:0] MODE_TANH       = 2'd1;
    localparam logic [1:0] MODE_LINEAR     = 2'd2;
    localparam logic [1:0] MODE_LINEAR_ALT = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE          = 3'd0;
    localparam logic [2:0] CFG_IN_SCALE      = 3'd1;
    localparam logic [2:0] CFG_IN_ZERO       = 3'd2;
    localparam logic [2:0] CFG_OUT_INV_SCALE = 3'd3;
    localparam logic [2:0] CFG_OUT_ZERO      = 3'd4;

    // log2(e) in Q1.30 and ln(2) in Q0.32
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    // exp result is zero once the integer exponent reaches this
    localparam logic [7:0] EXP_ZERO_SHIFT = 8'd40;

    // largest result magnitude before the zero point is added
    localparam logic [10:0] MAG_LIMIT = 11'd1024;

    // floor(2^32 / k) for the series divisors
    localparam logic [31:0] DIV_RECIP [2:13] = '{
        32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
        32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099
    };

    // configuration register set
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] in_scale;
        logic [7:0]  in_zero;
        logic [31:0] out_inv_scale;
        logic [7:0]  out_zero;
    } t_cfg;

    // per-item control that travels with the data
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        neg;
        logic [10:0] lin_mag;
    } t_side;

endpackage

`default_nettype wire

// File: src/iar_front.sv
// ----------------------------------------------------------------------------
// iar_front
// Zero point removal, input scaling, linear requantize and exp argument prep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iar_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire iar_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_sample,
    input  wire logic           i_last_in,
    output iar_pkg::t_side      o_side,
    output logic [31:0]         o_y,
    output logic [7:0]          o_n
);

    localparam int LIN_SHIFT = iar_pkg::IN_FRAC + iar_pkg::OUT_FRAC - 1;

    iar_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [7:0]  r1_mag;
    logic [39:0] r2_p;
    logic [63:0] r3_lo;
    logic [7:0]  r3_ph;
    logic [31:0] r3_te;
    logic [63:0] r4_lo;
    logic [39:0] r4_hi;
    logic [62:0] r4_uprod;
    logic [7:0]  r5_n;
    logic [55:0] r5_yprod;

    logic [8:0]  w_d;
    logic [8:0]  w_dabs;
    logic [47:0] w_t;
    logic [30:0] w_tc;
    logic [31:0] w_te;
    logic [71:0] w_full;
    logic [71:0] w_m;
    logic [71:0] w_rm;
    logic [10:0] w_lin;
    logic [31:0] w_u;

    // signed difference and its magnitude
    assign w_d    = {i_sample[7], i_sample} - {i_cfg.in_zero[7], i_cfg.in_zero};
    assign w_dabs = w_d[8] ? (9'd0 - w_d) : w_d;

    // scaled magnitude to Q24.24
    generate
        if (iar_pkg::IN_FRAC >= 24) begin : g_tshr
            assign w_t = {8'd0, r2_p} >> (iar_pkg::IN_FRAC - 24);
        end else begin : g_tshl
            assign w_t = {8'd0, r2_p} << (24 - iar_pkg::IN_FRAC);
        end
    endgenerate

    // clamp to 64.0, doubled for tanh
    assign w_tc = (w_t > 48'h0000_4000_0000) ? 31'h4000_0000 : w_t[30:0];
    assign w_te = (i_cfg.mode == iar_pkg::MODE_TANH) ? {w_tc, 1'b0} : {1'b0, w_tc};

    // linear path rounding and clamp
    assign w_full = {r4_hi, 32'd0} + {8'd0, r4_lo};
    assign w_m    = w_full >> LIN_SHIFT;
    assign w_rm   = (w_m + 72'd1) >> 1;
    assign w_lin  = (w_rm > 72'(iar_pkg::MAG_LIMIT)) ? iar_pkg::MAG_LIMIT : w_rm[10:0];

    // exponent split of t*log2(e)
    assign w_u = r4_uprod[61:30];

    // valid bits and datapath stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
            r2_side.valid <= 1'b0;
            r3_side.valid <= 1'b0;
            r4_side.valid <= 1'b0;
            r5_side.valid <= 1'b0;
        end else if (i_adv) begin
            r1_side.valid <= i_valid;
            r2_side.valid <= r1_side.valid;
            r3_side.valid <= r2_side.valid;
            r4_side.valid <= r3_side.valid;
            r5_side.valid <= r4_side.valid;

            r1_side.last    <= i_last_in;
            r1_side.neg     <= w_d[8];
            r1_side.lin_mag <= '0;
            r1_mag          <= w_dabs[7:0];

            r2_side.last    <= r1_side.last;
            r2_side.neg     <= r1_side.neg;
            r2_side.lin_mag <= r1_side.lin_mag;
            r2_p            <= 40'(r1_mag) * 40'(i_cfg.in_scale);

            r3_side.last    <= r2_side.last;
            r3_side.neg     <= r2_side.neg;
            r3_side.lin_mag <= r2_side.lin_mag;
            r3_lo           <= 64'(r2_p[31:0]) * 64'(i_cfg.out_inv_scale);
            r3_ph           <= r2_p[39:32];
            r3_te           <= w_te;

            r4_side.last    <= r3_side.last;
            r4_side.neg     <= r3_side.neg;
            r4_side.lin_mag <= r3_side.lin_mag;
            r4_lo           <= r3_lo;
            r4_hi           <= 40'(r3_ph) * 40'(i_cfg.out_inv_scale);
            r4_uprod        <= 63'(r3_te) * 63'(iar_pkg::LOG2E_Q30);

            r5_side.last    <= r4_side.last;
            r5_side.neg     <= r4_side.neg;
            r5_side.lin_mag <= w_lin;
            r5_n            <= w_u[31:24];
            r5_yprod        <= 56'(w_u[23:0]) * 56'(iar_pkg::LN2_Q32);
        end
    end

    assign o_side = r5_side;
    assign o_y    = r5_yprod[55:24];
    assign o_n    = r5_n;

endmodule

`default_nettype wire

// File: src/iar_exp.sv
// ----------------------------------------------------------------------------
// iar_exp
// Pipelined exp(-t): series of exp(-f*ln2) up to the y^13 term, then scaled by 2^-n.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iar_exp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire iar_pkg::t_side i_side,
    input  wire logic [31:0]    i_y,
    input  wire logic [7:0]     i_n,
    output iar_pkg::t_side      o_side,
    output logic [32:0]         o_e
);

    typedef struct packed {
        iar_pkg::t_side side;
        logic [31:0]    y;
        logic [7:0]     n;
        logic [32:0]    sum;
        logic [31:0]    x;
        logic [31:0]    q0;
    } t_exp_st;

    t_exp_st r_a [2:13];
    t_exp_st r_b [2:13];
    t_exp_st r_c [1:13];

    iar_pkg::t_side r_side;
    logic [32:0]    r_e;

    // first term is y itself
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[1].side.valid <= 1'b0;
        end else if (i_adv) begin
            r_c[1].side <= i_side;
            r_c[1].y    <= i_y;
            r_c[1].n    <= i_n;
            r_c[1].sum  <= 33'h1_0000_0000 - {1'b0, i_y};
            r_c[1].x    <= i_y;
            r_c[1].q0   <= '0;
        end
    end

    // one term per three stages: multiply, reciprocal multiply, correct and sum
    generate
        for (genvar k = 2; k <= 13; k++) begin : g_term
            logic [63:0] w_pa;
            logic [63:0] w_pb;
            logic [31:0] w_rem;
            logic [31:0] w_q;
            t_exp_st     w_a;
            t_exp_st     w_b;
            t_exp_st     w_c;

            assign w_pa  = 64'(r_c[k-1].x) * 64'(r_c[k-1].y);
            assign w_pb  = 64'(r_a[k].x) * 64'(iar_pkg::DIV_RECIP[k]);
            assign w_rem = r_b[k].x - 32'(r_b[k].q0 * 32'(k));
            assign w_q   = (w_rem >= 32'(k)) ? (r_b[k].q0 + 32'd1) : r_b[k].q0;

            always_comb begin
                w_a   = r_c[k-1];
                w_a.x = w_pa[63:32];
                w_b    = r_a[k];
                w_b.q0 = w_pb[63:32];
                w_c   = r_b[k];
                w_c.x = w_q;
                if (k % 2 == 1) begin
                    w_c.sum = r_b[k].sum - {1'b0, w_q};
                end else begin
                    w_c.sum = r_b[k].sum + {1'b0, w_q};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_a[k].side.valid <= 1'b0;
                    r_b[k].side.valid <= 1'b0;
                    r_c[k].side.valid <= 1'b0;
                end else if (i_adv) begin
                    r_a[k] <= w_a;
                    r_b[k] <= w_b;
                    r_c[k] <= w_c;
                end
            end
        end
    endgenerate

    // scale by 2^-n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_adv) begin
            r_side <= r_c[13].side;
            r_e    <= (r_c[13].n >= iar_pkg::EXP_ZERO_SHIFT) ? 33'd0
                                                             : (r_c[13].sum >> r_c[13].n[5:0]);
        end
    end

    assign o_side = r_side;
    assign o_e    = r_e;

endmodule

`default_nettype wire

// File: src/iar_div.sv
// ----------------------------------------------------------------------------
// iar_div
// Function value as a Q1.30 quotient, restoring division one bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iar_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire iar_pkg::t_cfg  i_cfg,
    input  wire iar_pkg::t_side i_side,
    input  wire logic [32:0]    i_e,
    output iar_pkg::t_side      o_side,
    output logic [30:0]         o_q
);

    typedef struct packed {
        iar_pkg::t_side side;
        logic [33:0]    rem;
        logic [33:0]    den;
        logic [30:0]    nbits;
        logic [30:0]    q;
    } t_div_st;

    t_div_st r_st [0:31];

    logic [62:0] w_num;
    logic [32:0] w_one_minus;

    // numerator per function
    assign w_one_minus = 33'h1_0000_0000 - i_e;
    always_comb begin
        if (i_cfg.mode == iar_pkg::MODE_SIGMOID) begin
            w_num = i_side.neg ? {i_e, 30'd0} : (63'd1 << 62);
        end else begin
            w_num = {w_one_minus, 30'd0};
        end
    end

    // load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].side.valid <= 1'b0;
        end else if (i_adv) begin
            r_st[0].side  <= i_side;
            r_st[0].rem   <= {2'd0, w_num[62:31]};
            r_st[0].den   <= 34'h1_0000_0000 + {1'b0, i_e};
            r_st[0].nbits <= w_num[30:0];
            r_st[0].q     <= '0;
        end
    end

    // one quotient bit per stage
    generate
        for (genvar i = 0; i < 31; i++) begin : g_bit
            logic [34:0] w_trial;
            logic        w_ge;
            logic [34:0] w_diff;
            t_div_st     w_nx;

            assign w_trial = {r_st[i].rem, r_st[i].nbits[30]};
            assign w_ge    = w_trial >= {1'b0, r_st[i].den};
            assign w_diff  = w_trial - {1'b0, r_st[i].den};

            always_comb begin
                w_nx       = r_st[i];
                w_nx.rem   = w_ge ? w_diff[33:0] : w_trial[33:0];
                w_nx.nbits = {r_st[i].nbits[29:0], 1'b0};
                w_nx.q     = {r_st[i].q[29:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[i+1].side.valid <= 1'b0;
                end else if (i_adv) begin
                    r_st[i+1] <= w_nx;
                end
            end
        end
    endgenerate

    assign o_side = r_st[31].side;
    assign o_q    = r_st[31].q;

endmodule

`default_nettype wire

// File: src/iar_back.sv
// ----------------------------------------------------------------------------
// iar_back
// Output scaling, rounding, zero point and saturation, plus output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iar_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire iar_pkg::t_cfg  i_cfg,
    input  wire iar_pkg::t_side i_side,
    input  wire logic [30:0]    i_q,
    output logic                o_valid,
    output logic [7:0]          o_result,
    output logic                o_last_out
);

    localparam int BACK_SHIFT = 29 + iar_pkg::OUT_FRAC;

    iar_pkg::t_side r1_side;
    logic [62:0]    r1_prod;
    logic           r_valid;
    logic [7:0]     r_result;
    logic           r_last;

    logic [62:0] w_sh;
    logic [62:0] w_rnd;
    logic [10:0] w_fmag;
    logic        w_func;
    logic        w_rneg;
    logic [10:0] w_mag;
    logic [11:0] w_sval;
    logic [7:0]  w_sat;

    // round half up on the magnitude, clamp
    assign w_sh   = r1_prod >> BACK_SHIFT;
    assign w_rnd  = (w_sh + 63'd1) >> 1;
    assign w_fmag = (w_rnd > 63'(iar_pkg::MAG_LIMIT)) ? iar_pkg::MAG_LIMIT : w_rnd[10:0];

    // select path and sign
    assign w_func = (i_cfg.mode == iar_pkg::MODE_SIGMOID) || (i_cfg.mode == iar_pkg::MODE_TANH);
    assign w_rneg = (i_cfg.mode == iar_pkg::MODE_SIGMOID) ? 1'b0 : r1_side.neg;
    assign w_mag  = w_func ? w_fmag : r1_side.lin_mag;
    assign w_sval = (w_rneg ? (12'd0 - {1'b0, w_mag}) : {1'b0, w_mag})
                    + {{4{i_cfg.out_zero[7]}}, i_cfg.out_zero};

    // saturate to int8
    always_comb begin
        if ($signed(w_sval) < -12'sd128) begin
            w_sat = 8'h80;
        end else if ($signed(w_sval) > 12'sd127) begin
            w_sat = 8'h7F;
        end else begin
            w_sat = w_sval[7:0];
        end
    end

    // valid bits, multiply and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else if (i_adv) begin
            r1_side.valid   <= i_side.valid;
            r_valid         <= r1_side.valid;
            r1_side.last    <= i_side.last;
            r1_side.neg     <= i_side.neg;
            r1_side.lin_mag <= i_side.lin_mag;
            r1_prod         <= 63'(i_q) * 63'(i_cfg.out_inv_scale);
            r_result        <= w_sat;
            r_last          <= r1_side.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_result   = r_result;
    assign o_last_out = r_last;

endmodule

`default_nettype wire

// File: src/int8_activation_requantize_unit.sv
// ----------------------------------------------------------------------------
// int8_activation_requantize_unit
// Streams int8 activations through sigmoid, tanh or linear requantization.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry i_sample and i_last_in. A transaction
// is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_result and o_last_out, one result
// transaction per input transaction, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 mode,
// 1 input scale, 2 input zero point, 3 reciprocal output scale, 4 output zero
// point); write only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
// The pipeline is 77 register stages deep, set by the exp series (three
// stages per term) and the one-bit-per-stage divider.
// Reset (synchronous, active low) clears all valid bits and loads mode
// sigmoid, unit scales and zero points of zero.
// When i_stall is high with a result waiting, the whole pipeline holds and
// o_stall goes high; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int8_activation_requantize_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_sample,
    input  wire logic        i_last_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_result,
    output logic             o_last_out
);

    iar_pkg::t_cfg  r_cfg;
    iar_pkg::t_side w_fr_side, w_ex_side, w_dv_side;
    logic [31:0]    w_y;
    logic [7:0]     w_n;
    logic [32:0]    w_e;
    logic [30:0]    w_q;
    logic           w_adv;

    // pipeline advances unless a finished result is held off
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= iar_pkg::MODE_SIGMOID;
            r_cfg.in_scale      <= 32'd1 << iar_pkg::IN_FRAC;
            r_cfg.in_zero       <= '0;
            r_cfg.out_inv_scale <= 32'd1 << iar_pkg::OUT_FRAC;
            r_cfg.out_zero      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iar_pkg::CFG_MODE:          r_cfg.mode          <= i_cfg_data[1:0];
                iar_pkg::CFG_IN_SCALE:      r_cfg.in_scale      <= i_cfg_data;
                iar_pkg::CFG_IN_ZERO:       r_cfg.in_zero       <= i_cfg_data[7:0];
                iar_pkg::CFG_OUT_INV_SCALE: r_cfg.out_inv_scale <= i_cfg_data;
                iar_pkg::CFG_OUT_ZERO:      r_cfg.out_zero      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    iar_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_sample  (i_sample),
        .i_last_in (i_last_in),
        .o_side    (w_fr_side),
        .o_y       (w_y),
        .o_n       (w_n)
    );

    iar_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_side  (w_fr_side),
        .i_y     (w_y),
        .i_n     (w_n),
        .o_side  (w_ex_side),
        .o_e     (w_e)
    );

    iar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .i_side  (w_ex_side),
        .i_e     (w_e),
        .o_side  (w_dv_side),
        .o_q     (w_q)
    );

    iar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_cfg      (r_cfg),
        .i_side     (w_dv_side),
        .i_q        (w_q),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .o_last_out (o_last_out)
    );

endmodule

`default_nettype wire
